// ===== rtl/ufib_pkg.sv =====
// ufib_pkg: shared types and constants of the uniform integer generator
// no dependencies; used by the interfaces, all rtl modules and the checker
`default_nettype none

package ufib_pkg;

   // fixed payload widths
   localparam int unsigned TYPE_W    = 2;
   localparam int unsigned BOUND_W   = 33;
   localparam int unsigned WIDTH_W   = 6;
   localparam int unsigned ENTROPY_W = 64;
   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned STATUS_W  = 2;

   // dice roller accumulators hold up to twice the largest bound
   localparam int unsigned ACC_W = BOUND_W + 1;

   // largest take width, and the width used for small compares
   localparam int unsigned TAKE_MAX = 32;
   localparam int unsigned CMP_W    = 8;

   // take bit counter indexes one bit of the value
   localparam int unsigned TCNT_W = $clog2(VALUE_W);

   // request codes
   typedef enum logic [TYPE_W-1:0] {
      REQ_REFILL = 2'd0,
      REQ_DRAW   = 2'd1,
      REQ_TAKE   = 2'd2
   } req_code_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_READY  = 2'd0,
      STATUS_NEED   = 2'd1,
      STATUS_BAD    = 2'd2,
      STATUS_LOADED = 2'd3
   } status_type;

   // kind of suspended request
   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_DRAW = 2'd1,
      KIND_TAKE = 2'd2
   } kind_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_DRAW,
      S_TAKE_CHECK,
      S_TAKE,
      S_FINISH
   } state_type;

   // commands to the bit pool
   typedef struct packed {
      logic load;
      logic shift;
      logic clear;
   } pool_cmd_type;

   // commands to the dice roller
   typedef struct packed {
      logic init;
      logic step;
   } roller_cmd_type;

   // roller feedback to the sequencer
   typedef struct packed {
      logic                 accept;
      logic [VALUE_W-1:0]   result;
   } roller_stat_type;

endpackage

`default_nettype wire

// ===== rtl/ufib_if.sv =====
// ufib request and response channel interfaces
// depends on ufib_pkg for the payload widths
`default_nettype none

interface ufib_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [ufib_pkg::TYPE_W-1:0]          req_type;
   logic [ufib_pkg::BOUND_W-1:0]         bound;
   logic [ufib_pkg::WIDTH_W-1:0]         take_width;
   logic [ufib_pkg::ENTROPY_W-1:0]       entropy_word;

   modport source (output valid, req_type, bound, take_width, entropy_word, input ready);
   modport sink   (input valid, req_type, bound, take_width, entropy_word, output ready);
endinterface

interface ufib_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [ufib_pkg::VALUE_W-1:0]         value;
   logic [ufib_pkg::STATUS_W-1:0]        status;

   modport source (output valid, value, status, input ready);
   modport sink   (input valid, value, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/uniform_integer_from_bit_pool.sv =====
// uniform_integer_from_bit_pool: top level, bit pool with a fast dice roller
// depends on ufib_pkg, ufib_if, ufib_pool, ufib_roller and ufib_ctrl
//
//   channel   direction   beat contents
//   req_ch    in          req_type, bound, take_width, entropy_word
//   rsp_ch    out         value, status (one beat per request beat)
//
// a draw uses one pool bit per roller step (about log2 of the bound plus a
// few) and ends with status need when the pool runs dry;
// a take of k bits moves one pool bit per cycle through the shift of the
// pool register
// a refill loads the pool, then does the work of the request it resumes
// one request at a time: req_ch is ready only while the sequencer is idle;
// the result register lets the next request in while a result is stalled
// synchronous reset empties the pool and drops any suspended request
`default_nettype none

module uniform_integer_from_bit_pool #(
   parameter int unsigned POOL_BITS  = 64,
   parameter int unsigned BOUND_BITS = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ufib_req_if.sink    req_ch,
   ufib_rsp_if.source  rsp_ch
);

   localparam int unsigned LEFT_W = $clog2(POOL_BITS + 1);

   ufib_pkg::pool_cmd_type     pool_cmd;
   ufib_pkg::roller_cmd_type   roller_cmd;
   ufib_pkg::roller_stat_type  roller_stat;
   logic                       pool_bit;
   logic [LEFT_W-1:0]          bits_left;
   logic [ufib_pkg::BOUND_W-1:0] roller_bound;

   // sequencer
   ufib_ctrl #(
      .POOL_BITS  (POOL_BITS),
      .BOUND_BITS (BOUND_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .pool_cmd     (pool_cmd),
      .pool_bit     (pool_bit),
      .bits_left    (bits_left),
      .roller_cmd   (roller_cmd),
      .roller_bound (roller_bound),
      .roller_stat  (roller_stat)
   );

   // bit pool
   ufib_pool #(
      .POOL_BITS (POOL_BITS)
   ) u_pool (
      .clock        (clock),
      .reset        (reset),
      .cmd          (pool_cmd),
      .entropy_word (req_ch.entropy_word),
      .pool_bit     (pool_bit),
      .bits_left    (bits_left)
   );

   // shared roller step unit
   ufib_roller u_roller (
      .clock    (clock),
      .reset    (reset),
      .cmd      (roller_cmd),
      .bound    (roller_bound),
      .pool_bit (pool_bit),
      .stat     (roller_stat)
   );

endmodule

`default_nettype wire

// ===== rtl/ufib_pool.sv =====
// ufib_pool: random bit pool with its unused bit count, shifted one bit a step
// depends on ufib_pkg
`default_nettype none

module ufib_pool #(
   parameter int unsigned POOL_BITS = 64,
   localparam int unsigned LEFT_W   = $clog2(POOL_BITS + 1)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ufib_pkg::pool_cmd_type          cmd,
   input  wire logic [ufib_pkg::ENTROPY_W-1:0]  entropy_word,
   output logic                                 pool_bit,
   output logic [LEFT_W-1:0]                    bits_left
);

   logic [POOL_BITS-1:0] pool_ff, pool_in;
   logic [LEFT_W-1:0]    left_ff, left_in;

   // load, consume one bit or discard everything
   always_comb begin
      pool_in = pool_ff;
      left_in = left_ff;
      if (cmd.load) begin
         pool_in = entropy_word[POOL_BITS-1:0];
         left_in = LEFT_W'(POOL_BITS);
      end else if (cmd.clear) begin
         pool_in = '0;
         left_in = '0;
      end else if (cmd.shift) begin
         pool_in = pool_ff >> 1;
         left_in = left_ff - LEFT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff <= '0;
         left_ff <= '0;
      end else begin
         pool_ff <= pool_in;
         left_ff <= left_in;
      end
   end

   assign pool_bit  = pool_ff[0];
   assign bits_left = left_ff;

endmodule

`default_nettype wire

// ===== rtl/ufib_roller.sv =====
// ufib_roller: fast dice roller accumulators, one pool bit per step
// depends on ufib_pkg
`default_nettype none

module ufib_roller (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire ufib_pkg::roller_cmd_type       cmd,
   input  wire logic [ufib_pkg::BOUND_W-1:0]   bound,
   input  wire logic                           pool_bit,
   output ufib_pkg::roller_stat_type           stat
);

   localparam int unsigned AW = ufib_pkg::ACC_W;

   logic [AW-1:0]                    range_ff, range_in;
   logic [AW-1:0]                    draw_ff, draw_in;
   logic [ufib_pkg::BOUND_W-1:0]     bound_ff, bound_in;
   logic [AW-1:0]                    range_dbl, draw_dbl, bound_ext;
   logic [AW:0]                      range_diff, draw_diff;
   logic                             range_ge, draw_lt;

   // doubled accumulators and their differences against the bound
   always_comb begin
      range_dbl  = {range_ff[AW-2:0], 1'b0};
      draw_dbl   = {draw_ff[AW-2:0], pool_bit};
      bound_ext  = {1'b0, bound_ff};
      range_diff = {1'b0, range_dbl} - {1'b0, bound_ext};
      draw_diff  = {1'b0, draw_dbl} - {1'b0, bound_ext};
      range_ge   = ~range_diff[AW];
      draw_lt    = draw_diff[AW];
   end

   // accumulator update
   always_comb begin
      range_in = range_ff;
      draw_in  = draw_ff;
      bound_in = bound_ff;
      if (cmd.init) begin
         range_in = AW'(1);
         draw_in  = '0;
         bound_in = bound;
      end else if (cmd.step) begin
         if (range_ge && !draw_lt) begin
            range_in = range_diff[AW-1:0];
            draw_in  = draw_diff[AW-1:0];
         end else begin
            range_in = range_dbl;
            draw_in  = draw_dbl;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= AW'(1);
         draw_ff  <= '0;
         bound_ff <= '0;
      end else begin
         range_ff <= range_in;
         draw_ff  <= draw_in;
         bound_ff <= bound_in;
      end
   end

   assign stat.accept = range_ge && draw_lt;
   assign stat.result = draw_dbl[ufib_pkg::VALUE_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/ufib_ctrl.sv =====
// ufib_ctrl: request sequencer, suspended request state and result register
// depends on ufib_pkg and the ufib channel interfaces
`default_nettype none

module ufib_ctrl #(
   parameter int unsigned POOL_BITS  = 64,
   parameter int unsigned BOUND_BITS = 32,
   localparam int unsigned LEFT_W    = $clog2(POOL_BITS + 1)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   ufib_req_if.sink                             req,
   ufib_rsp_if.source                           rsp,
   output ufib_pkg::pool_cmd_type               pool_cmd,
   input  wire logic                            pool_bit,
   input  wire logic [LEFT_W-1:0]               bits_left,
   output ufib_pkg::roller_cmd_type             roller_cmd,
   output logic [ufib_pkg::BOUND_W-1:0]         roller_bound,
   input  wire ufib_pkg::roller_stat_type       roller_stat
);

   localparam int unsigned VW = ufib_pkg::VALUE_W;
   localparam int unsigned CW = ufib_pkg::CMP_W;
   localparam logic [63:0] BOUND_LIMIT = 64'd1 << BOUND_BITS;
   localparam logic [CW-1:0] POOL_LIMIT = CW'(POOL_BITS);
   localparam logic [CW-1:0] TAKE_LIMIT = CW'(ufib_pkg::TAKE_MAX);

   ufib_pkg::state_type                  state_ff, state_in;
   ufib_pkg::kind_type                   kind_ff, kind_in;
   logic [ufib_pkg::WIDTH_W-1:0]         pwidth_ff, pwidth_in;
   logic [ufib_pkg::TCNT_W-1:0]          cnt_ff, cnt_in;
   logic [ufib_pkg::TYPE_W-1:0]          lreq_type_ff, lreq_type_in;
   logic [ufib_pkg::BOUND_W-1:0]         lreq_bound_ff, lreq_bound_in;
   logic [ufib_pkg::WIDTH_W-1:0]         lreq_width_ff, lreq_width_in;
   logic [VW-1:0]                        work_value_ff, work_value_in;
   ufib_pkg::status_type                 work_status_ff, work_status_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                        rsp_value_ff, rsp_value_in;
   ufib_pkg::status_type                 rsp_status_ff, rsp_status_in;

   logic bound_bad, take_bad, left_zero, too_few, take_last, out_free;

   // request checks and pool conditions
   always_comb begin
      bound_bad = (lreq_bound_ff == '0) || ({31'b0, lreq_bound_ff} > BOUND_LIMIT);
      take_bad  = ({2'b0, lreq_width_ff} > TAKE_LIMIT) || ({2'b0, lreq_width_ff} > POOL_LIMIT);
      left_zero = (bits_left == '0);
      too_few   = (CW'(bits_left) < {2'b0, pwidth_ff});
      take_last = ({1'b0, cnt_ff} == (pwidth_ff - 6'd1));
      out_free  = !rsp_valid_ff || rsp.ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ufib_pkg::S_IDLE: begin
            if (req.valid) state_in = ufib_pkg::S_DISPATCH;
         end
         ufib_pkg::S_DISPATCH: begin
            case (lreq_type_ff)
               ufib_pkg::REQ_REFILL: begin
                  case (kind_ff)
                     ufib_pkg::KIND_DRAW: state_in = ufib_pkg::S_DRAW;
                     ufib_pkg::KIND_TAKE: state_in = ufib_pkg::S_TAKE_CHECK;
                     default:             state_in = ufib_pkg::S_FINISH;
                  endcase
               end
               ufib_pkg::REQ_DRAW: begin
                  state_in = bound_bad ? ufib_pkg::S_FINISH : ufib_pkg::S_DRAW;
               end
               ufib_pkg::REQ_TAKE: begin
                  state_in = take_bad ? ufib_pkg::S_FINISH : ufib_pkg::S_TAKE_CHECK;
               end
               default: state_in = ufib_pkg::S_FINISH;
            endcase
         end
         ufib_pkg::S_DRAW: begin
            if (left_zero || roller_stat.accept) state_in = ufib_pkg::S_FINISH;
         end
         ufib_pkg::S_TAKE_CHECK: begin
            if (too_few || pwidth_ff == '0) state_in = ufib_pkg::S_FINISH;
            else                            state_in = ufib_pkg::S_TAKE;
         end
         ufib_pkg::S_TAKE: begin
            if (take_last) state_in = ufib_pkg::S_FINISH;
         end
         ufib_pkg::S_FINISH: begin
            if (out_free) state_in = ufib_pkg::S_IDLE;
         end
         default: state_in = ufib_pkg::S_IDLE;
      endcase
   end

   // commands and register updates per state
   always_comb begin
      pool_cmd       = '0;
      roller_cmd     = '0;
      kind_in        = kind_ff;
      pwidth_in      = pwidth_ff;
      cnt_in         = cnt_ff;
      lreq_type_in   = lreq_type_ff;
      lreq_bound_in  = lreq_bound_ff;
      lreq_width_in  = lreq_width_ff;
      work_value_in  = work_value_ff;
      work_status_in = work_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      case (state_ff)
         ufib_pkg::S_IDLE: begin
            // latch the beat; a refill loads the pool straight away
            if (req.valid) begin
               lreq_type_in  = req.req_type;
               lreq_bound_in = req.bound;
               lreq_width_in = req.take_width;
               pool_cmd.load = (req.req_type == ufib_pkg::REQ_REFILL);
            end
         end
         ufib_pkg::S_DISPATCH: begin
            work_value_in = '0;
            case (lreq_type_ff)
               ufib_pkg::REQ_REFILL: begin
                  if (kind_ff == ufib_pkg::KIND_NONE) work_status_in = ufib_pkg::STATUS_LOADED;
               end
               ufib_pkg::REQ_DRAW: begin
                  if (bound_bad) begin
                     work_status_in = ufib_pkg::STATUS_BAD;
                  end else begin
                     kind_in         = ufib_pkg::KIND_DRAW;
                     roller_cmd.init = 1'b1;
                  end
               end
               ufib_pkg::REQ_TAKE: begin
                  if (take_bad) begin
                     work_status_in = ufib_pkg::STATUS_BAD;
                  end else begin
                     kind_in   = ufib_pkg::KIND_TAKE;
                     pwidth_in = lreq_width_ff;
                  end
               end
               default: work_status_in = ufib_pkg::STATUS_BAD;
            endcase
         end
         ufib_pkg::S_DRAW: begin
            // one roller step per pool bit
            if (left_zero) begin
               work_status_in = ufib_pkg::STATUS_NEED;
            end else begin
               pool_cmd.shift  = 1'b1;
               roller_cmd.step = 1'b1;
               if (roller_stat.accept) begin
                  work_value_in  = roller_stat.result;
                  work_status_in = ufib_pkg::STATUS_READY;
                  kind_in        = ufib_pkg::KIND_NONE;
               end
            end
         end
         ufib_pkg::S_TAKE_CHECK: begin
            cnt_in = '0;
            if (too_few) begin
               pool_cmd.clear = 1'b1;
               work_status_in = ufib_pkg::STATUS_NEED;
            end else if (pwidth_ff == '0) begin
               work_status_in = ufib_pkg::STATUS_READY;
               kind_in        = ufib_pkg::KIND_NONE;
            end
         end
         ufib_pkg::S_TAKE: begin
            // move one pool bit into the value, low bits first
            pool_cmd.shift        = 1'b1;
            work_value_in[cnt_ff] = pool_bit;
            cnt_in                = cnt_ff + ufib_pkg::TCNT_W'(1);
            if (take_last) begin
               work_status_in = ufib_pkg::STATUS_READY;
               kind_in        = ufib_pkg::KIND_NONE;
            end
         end
         ufib_pkg::S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = work_value_ff;
               rsp_status_in = work_status_ff;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ufib_pkg::S_IDLE;
         kind_ff      <= ufib_pkg::KIND_NONE;
         pwidth_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         pwidth_ff    <= pwidth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      lreq_type_ff   <= lreq_type_in;
      lreq_bound_ff  <= lreq_bound_in;
      lreq_width_ff  <= lreq_width_in;
      work_value_ff  <= work_value_in;
      work_status_ff <= work_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign req.ready    = (state_ff == ufib_pkg::S_IDLE);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.value    = rsp_value_ff;
   assign rsp.status   = rsp_status_ff;
   assign roller_bound = lreq_bound_ff;

endmodule

`default_nettype wire

// ===== rtl/ufib_checker.sv =====
// ufib_checker: port level assertions for uniform_integer_from_bit_pool
// depends on ufib_pkg; bound to the top level at the end of this file
`default_nettype none

module ufib_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire logic [ufib_pkg::VALUE_W-1:0]        rsp_value,
   input  wire logic [ufib_pkg::STATUS_W-1:0]       rsp_status
);

   // a stalled response beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // an accepted request keeps the input closed on the next cycle
   a_req_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on consecutive cycles");

   // only a ready status carries a value
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ufib_pkg::STATUS_READY) |-> rsp_value == '0)
      else $error("non-zero value with a non-ready status");

   // nothing is offered straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response offered after reset");

endmodule

bind uniform_integer_from_bit_pool ufib_checker u_ufib_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_value  (rsp_ch.value),
   .rsp_status (rsp_ch.status)
);

`default_nettype wire

// ===== test/testbench.sv =====
// testbench for uniform_integer_from_bit_pool: draws, takes and refills checked per beat
// against an in-bench model of the pool and dice roller
// depends on ufib_pkg, ufib_if and the rtl of uniform_integer_from_bit_pool

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned POOL_BITS  = 64;
   localparam int unsigned BOUND_BITS = 32;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned LONG_HOLD = 300;
   localparam int unsigned RANDOM_BEATS = 1300;

   localparam logic [ufib_pkg::TYPE_W-1:0]    REQ_UNDEFINED = 2'd3;
   localparam logic [ufib_pkg::BOUND_W-1:0]   BOUND_TOP     = 33'h1_0000_0000;
   localparam logic [ufib_pkg::ENTROPY_W-1:0] ALL_ONES      = '1;

   typedef enum logic [1:0] {
      ACT_BEAT,
      ACT_DRAIN,
      ACT_HOLD
   } step_kind_type;

   typedef struct {
      step_kind_type                      step;
      logic [ufib_pkg::TYPE_W-1:0]        req_type;
      logic [ufib_pkg::BOUND_W-1:0]       bound;
      logic [ufib_pkg::WIDTH_W-1:0]       take_width;
      logic [ufib_pkg::ENTROPY_W-1:0]     entropy_word;
   } request_type;

   typedef struct {
      logic [ufib_pkg::VALUE_W-1:0] value;
      ufib_pkg::status_type         status;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ufib_req_if req_ch ();
   ufib_rsp_if rsp_ch ();

   uniform_integer_from_bit_pool dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // clock
   always #5 clock = ~clock;

   request_type request_q[$];
   outcome_type outcomes_due[$];

   int unsigned bad_results = 0;
   int unsigned results_seen = 0;
   int unsigned cycle_count = 0;
   logic        beat_taken = 1'b0;
   int unsigned gap_left = 0;
   int unsigned hold_asks = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   int unsigned stall_left = 0;
   bit          calm_sender = 1'b0;
   bit          calm_receiver = 1'b0;

   // model state of the pool and the roller
   logic [ufib_pkg::ENTROPY_W-1:0] pool;
   int unsigned                    pool_count;
   logic [ufib_pkg::ACC_W-1:0]     span;
   logic [ufib_pkg::ACC_W-1:0]     roll;
   logic [ufib_pkg::BOUND_W-1:0]   held_bound;
   ufib_pkg::kind_type             held_kind;
   logic [ufib_pkg::WIDTH_W-1:0]   held_width;

   // fast dice roller, one pool bit per step; 1 when a value is accepted
   function automatic bit roll_dice(output logic [ufib_pkg::VALUE_W-1:0] drawn);
      logic [ufib_pkg::ACC_W-1:0] limit;
      limit = {1'b0, held_bound};
      drawn = '0;
      while (pool_count > 0) begin
         roll = {roll[ufib_pkg::ACC_W-2:0], pool[0]};
         span = span << 1;
         pool = pool >> 1;
         pool_count--;
         if (span >= limit) begin
            if (roll < limit) begin
               drawn = roll[ufib_pkg::VALUE_W-1:0];
               held_kind = ufib_pkg::KIND_NONE;
               return 1'b1;
            end
            span -= limit;
            roll -= limit;
         end
      end
      return 1'b0;
   endfunction

   // raw bits, low first; 1 when enough were in the pool
   function automatic bit take_pool_bits(output logic [ufib_pkg::VALUE_W-1:0] got);
      logic [ufib_pkg::ENTROPY_W-1:0] picked;
      got = '0;
      if (pool_count < held_width)
         return 1'b0;
      picked = pool & ((64'd1 << held_width) - 64'd1);
      got = picked[ufib_pkg::VALUE_W-1:0];
      pool = pool >> held_width;
      pool_count -= held_width;
      held_kind = ufib_pkg::KIND_NONE;
      return 1'b1;
   endfunction

   // expected result of one accepted request beat, updating the model state
   function automatic outcome_type outcome_of(request_type b);
      outcome_type r;
      logic [ufib_pkg::VALUE_W-1:0] v;
      bit done;
      r.value = '0;
      r.status = ufib_pkg::STATUS_BAD;
      case (b.req_type)
         ufib_pkg::REQ_REFILL: begin
            pool = b.entropy_word & (ALL_ONES >> (64 - POOL_BITS));
            pool_count = POOL_BITS;
            if (held_kind == ufib_pkg::KIND_DRAW || held_kind == ufib_pkg::KIND_TAKE) begin
               done = (held_kind == ufib_pkg::KIND_DRAW) ? roll_dice(v) : take_pool_bits(v);
               r.status = done ? ufib_pkg::STATUS_READY : ufib_pkg::STATUS_NEED;
               r.value = done ? v : '0;
            end else begin
               r.status = ufib_pkg::STATUS_LOADED;
            end
         end
         ufib_pkg::REQ_DRAW: begin
            if (b.bound != '0 && b.bound <= (ufib_pkg::BOUND_W'(1) << BOUND_BITS)) begin
               held_kind = ufib_pkg::KIND_DRAW;
               held_bound = b.bound;
               span = 1;
               roll = 0;
               done = roll_dice(v);
               r.status = done ? ufib_pkg::STATUS_READY : ufib_pkg::STATUS_NEED;
               r.value = done ? v : '0;
            end
         end
         ufib_pkg::REQ_TAKE: begin
            if (b.take_width <= ufib_pkg::TAKE_MAX && b.take_width <= POOL_BITS) begin
               held_kind = ufib_pkg::KIND_TAKE;
               held_width = b.take_width;
               if (take_pool_bits(v)) begin
                  r.status = ufib_pkg::STATUS_READY;
                  r.value = v;
               end else begin
                  // too few bits: the rest is thrown away
                  pool = '0;
                  pool_count = 0;
                  r.status = ufib_pkg::STATUS_NEED;
               end
            end
         end
         default: r.status = ufib_pkg::STATUS_BAD;
      endcase
      return r;
   endfunction

   // beat with random filler in the fields the request does not use
   function automatic request_type make_beat(logic [ufib_pkg::TYPE_W-1:0] kind,
                                             logic [ufib_pkg::BOUND_W-1:0] n,
                                             logic [ufib_pkg::WIDTH_W-1:0] k,
                                             logic [ufib_pkg::ENTROPY_W-1:0] w);
      request_type b;
      b.step = ACT_BEAT;
      b.req_type = kind;
      b.bound = (kind == ufib_pkg::REQ_DRAW) ? n : {1'($urandom_range(0, 1)), $urandom};
      b.take_width = (kind == ufib_pkg::REQ_TAKE) ? k
                                                  : ufib_pkg::WIDTH_W'($urandom_range(0, 63));
      b.entropy_word = (kind == ufib_pkg::REQ_REFILL) ? w : {$urandom, $urandom};
      return b;
   endfunction

   function automatic request_type marker(step_kind_type s);
      request_type b;
      b = make_beat(ufib_pkg::REQ_REFILL, '0, '0, '0);
      b.step = s;
      return b;
   endfunction

   // legal bound of random magnitude, 1 up to 2^32
   function automatic logic [ufib_pkg::BOUND_W-1:0] pick_bound();
      int unsigned w;
      logic [ufib_pkg::ENTROPY_W-1:0] r;
      w = $urandom_range(0, 32);
      if (w == 32 && $urandom_range(0, 7) == 0)
         return BOUND_TOP;
      r = {32'd0, $urandom} & ((64'd1 << w) - 64'd1);
      return ufib_pkg::BOUND_W'(r + 64'd1);
   endfunction

   function automatic logic [ufib_pkg::ENTROPY_W-1:0] pick_word();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0)
         return ALL_ONES;
      if (r == 1)
         return '0;
      return {$urandom, $urandom};
   endfunction

   // sender gap: mostly none, some short, a few long, with calm stretches
   function automatic int unsigned pick_gap();
      int unsigned r;
      if ($urandom_range(0, 63) == 0)
         calm_sender = !calm_sender;
      if (calm_sender)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // request driver, inputs change on the falling edge
   always @(negedge clock) begin : drive_requests
      int unsigned gap;
      request_type b;
      gap = gap_left;
      if (req_ch.valid && beat_taken)
         gap = pick_gap();
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !beat_taken) begin
         // beat still on offer
      end else if (gap > 0) begin
         req_ch.valid <= 1'b0;
         gap_left <= gap - 1;
      end else if (request_q.size() == 0) begin
         req_ch.valid <= 1'b0;
      end else if (request_q[0].step == ACT_HOLD) begin
         hold_asks <= hold_asks + 1;
         void'(request_q.pop_front());
         req_ch.valid <= 1'b0;
      end else if (request_q[0].step == ACT_DRAIN) begin
         if (outcomes_due.size() == 0)
            void'(request_q.pop_front());
         req_ch.valid <= 1'b0;
      end else begin
         b = request_q.pop_front();
         req_ch.valid <= 1'b1;
         req_ch.req_type <= b.req_type;
         req_ch.bound <= b.bound;
         req_ch.take_width <= b.take_width;
         req_ch.entropy_word <= b.entropy_word;
         gap_left <= 0;
      end
   end

   // result ready: long hold on request, otherwise random stalls
   always @(negedge clock) begin : drive_ready
      int unsigned r;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0)
            calm_receiver = !calm_receiver;
         r = $urandom_range(0, 99);
         if (calm_receiver || r < 70) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b0;
            stall_left <= (r < 96) ? $urandom_range(0, 2) : $urandom_range(8, 40);
         end
      end
   end

   // monitor: predict on each request beat, check each result beat
   always @(posedge clock) begin : watch_beats
      request_type b;
      outcome_type want;
      if (reset) begin
         beat_taken <= 1'b0;
      end else begin
         beat_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            b.step = ACT_BEAT;
            b.req_type = req_ch.req_type;
            b.bound = req_ch.bound;
            b.take_width = req_ch.take_width;
            b.entropy_word = req_ch.entropy_word;
            outcomes_due.push_back(outcome_of(b));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (outcomes_due.size() == 0) begin
               bad_results++;
               if (bad_results <= 10)
                  $display("result %0d with nothing outstanding: value %h status %0d",
                           results_seen, rsp_ch.value, rsp_ch.status);
            end else begin
               want = outcomes_due.pop_front();
               if (rsp_ch.value !== want.value || rsp_ch.status !== want.status) begin
                  bad_results++;
                  if (bad_results <= 10)
                     $display("result %0d: value %h expected %h, status %0d expected %0d",
                              results_seen, rsp_ch.value, want.value,
                              rsp_ch.status, want.status);
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL uniform_integer_from_bit_pool");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int unsigned r;
      req_ch.valid = 1'b0;
      req_ch.req_type = ufib_pkg::REQ_REFILL;
      req_ch.bound = '0;
      req_ch.take_width = '0;
      req_ch.entropy_word = '0;
      rsp_ch.ready = 1'b0;
      pool = '0;
      pool_count = 0;
      span = 1;
      roll = 0;
      held_bound = '0;
      held_kind = ufib_pkg::KIND_NONE;
      held_width = '0;

      // directed: empty pool, suspension, resumption and rejected requests
      request_q.push_back(make_beat(ufib_pkg::REQ_TAKE, '0, 6'd5, '0));
      request_q.push_back(make_beat(ufib_pkg::REQ_TAKE, '0, 6'd0, '0));
      request_q.push_back(make_beat(ufib_pkg::REQ_DRAW, 33'd10, '0, '0));
      request_q.push_back(make_beat(ufib_pkg::REQ_REFILL, '0, '0, {$urandom, $urandom}));
      request_q.push_back(make_beat(ufib_pkg::REQ_REFILL, '0, '0, {$urandom, $urandom}));
      request_q.push_back(make_beat(ufib_pkg::REQ_DRAW, 33'd0, '0, '0));
      request_q.push_back(make_beat(ufib_pkg::REQ_DRAW, BOUND_TOP + 33'd1, '0, '0));
      request_q.push_back(make_beat(ufib_pkg::REQ_DRAW, '1, '0, '0));
      request_q.push_back(make_beat(REQ_UNDEFINED, '0, '0, '0));
      request_q.push_back(make_beat(ufib_pkg::REQ_TAKE, '0, 6'd33, '0));
      request_q.push_back(make_beat(ufib_pkg::REQ_TAKE, '0, 6'd63, '0));
      request_q.push_back(make_beat(ufib_pkg::REQ_TAKE, '0, 6'd32, '0));
      request_q.push_back(make_beat(ufib_pkg::REQ_TAKE, '0, 6'd32, '0));
      request_q.push_back(make_beat(ufib_pkg::REQ_TAKE, '0, 6'd1, '0));
      request_q.push_back(make_beat(ufib_pkg::REQ_REFILL, '0, '0, ALL_ONES));
      request_q.push_back(make_beat(ufib_pkg::REQ_DRAW, 33'd1, '0, '0));
      request_q.push_back(make_beat(ufib_pkg::REQ_DRAW, BOUND_TOP, '0, '0));
      // all-ones pool keeps rejecting a bound of 2^32 - 1, so the draw runs dry twice
      request_q.push_back(make_beat(ufib_pkg::REQ_REFILL, '0, '0, ALL_ONES));
      request_q.push_back(make_beat(ufib_pkg::REQ_DRAW, BOUND_TOP - 33'd1, '0, '0));
      request_q.push_back(make_beat(ufib_pkg::REQ_REFILL, '0, '0, ALL_ONES));
      request_q.push_back(make_beat(ufib_pkg::REQ_REFILL, '0, '0, {$urandom, $urandom}));
      // draw of 2^32 - 1 on the bits left, then a take that finds the pool empty
      request_q.push_back(make_beat(ufib_pkg::REQ_DRAW, BOUND_TOP - 33'd1, '0, '0));
      request_q.push_back(make_beat(ufib_pkg::REQ_TAKE, '0, 6'd4, '0));
      request_q.push_back(make_beat(ufib_pkg::REQ_REFILL, '0, '0, '0));
      request_q.push_back(make_beat(ufib_pkg::REQ_DRAW, 33'd1000, '0, '0));

      // random: mostly legal refill, draw and take mixes, some rejected requests
      for (int unsigned i = 0; i < RANDOM_BEATS; i++) begin
         if (i == 400)
            request_q.push_back(marker(ACT_DRAIN));
         if (i == 700 || i == 1100)
            request_q.push_back(marker(ACT_HOLD));
         r = $urandom_range(0, 99);
         if (r < 28)
            request_q.push_back(make_beat(ufib_pkg::REQ_REFILL, '0, '0, pick_word()));
         else if (r < 62)
            request_q.push_back(make_beat(ufib_pkg::REQ_DRAW, pick_bound(), '0, '0));
         else if (r < 88)
            request_q.push_back(make_beat(ufib_pkg::REQ_TAKE, '0,
                                          ufib_pkg::WIDTH_W'($urandom_range(0, 32)), '0));
         else if (r < 92)
            request_q.push_back(make_beat(ufib_pkg::REQ_TAKE, '0,
                                          ufib_pkg::WIDTH_W'($urandom_range(33, 63)), '0));
         else if (r < 96)
            request_q.push_back(make_beat(ufib_pkg::REQ_DRAW,
                                          ($urandom_range(0, 3) == 0) ? '0
                                             : {1'b1, $urandom | 32'd1}, '0, '0));
         else
            request_q.push_back(make_beat(REQ_UNDEFINED, '0, '0, '0));
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // all beats offered and taken, then every result back
      while (request_q.size() != 0 || req_ch.valid)
         @(posedge clock);
      while (outcomes_due.size() != 0)
         @(posedge clock);
      repeat (120) @(posedge clock);

      if (bad_results == 0)
         $display("PASS uniform_integer_from_bit_pool");
      else
         $display("FAIL uniform_integer_from_bit_pool");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ufib_pkg.sv
rtl/ufib_if.sv
rtl/ufib_pool.sv
rtl/ufib_roller.sv
rtl/ufib_ctrl.sv
rtl/uniform_integer_from_bit_pool.sv
rtl/ufib_checker.sv
test/testbench.sv
